// File: rtl/core/cmm_pkg.sv
`default_nettype none

package cmm_pkg;

  // Fixed widths of the interface fields.
  localparam int IDX_W = 3;
  localparam int DIM_W = 4;
  localparam int ACC_W = 36;

  // Command codes carried on the opcode port.
  typedef enum logic [1:0] {
    OP_LOAD_LEFT  = 2'd0,
    OP_LOAD_RIGHT = 2'd1,
    OP_COMPUTE    = 2'd2,
    OP_NONE       = 2'd3
  } opcode_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROWS  = 2'd0;
  localparam logic [1:0] CFG_INNER = 2'd1;
  localparam logic [1:0] CFG_COLS  = 2'd2;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // One multiply-accumulate step issued by the sequencer.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
  } step_t;

  // Highest loop index for a size register: zero counts as one and sizes
  // above the store dimension are cut to it.
  function automatic logic [IDX_W-1:0] dim_limit(input logic [DIM_W-1:0] d,
                                                 input logic [DIM_W-1:0] max_d);
    logic [DIM_W-1:0] c;
    begin
      if (d == '0) begin
        c = DIM_W'(1);
      end else if (d > max_d) begin
        c = max_d;
      end else begin
        c = d;
      end
      dim_limit = IDX_W'(c - DIM_W'(1));
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/cmm_store.sv
`default_nettype none

// Matrix element store: one write port, one read port with registered data.
module cmm_store #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [0:DEPTH-1];

  // Write side.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read side, registered data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/cmm_seq.sv
`default_nettype none

// Step sequencer: walks row, column and inner index of one product and
// issues one multiply-accumulate step per cycle.
module cmm_seq (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire logic [cmm_pkg::IDX_W-1:0]  row_lim,
  input  wire logic [cmm_pkg::IDX_W-1:0]  inner_lim,
  input  wire logic [cmm_pkg::IDX_W-1:0]  col_lim,
  output logic                            busy,
  output cmm_pkg::step_t                  step
);

  cmm_pkg::state_t            state, state_next;
  logic [cmm_pkg::IDX_W-1:0]  row, row_next;
  logic [cmm_pkg::IDX_W-1:0]  col, col_next;
  logic [cmm_pkg::IDX_W-1:0]  k, k_next;

  // State and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmm_pkg::ST_IDLE;
      row   <= '0;
      col   <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      k     <= k_next;
    end
  end

  // Next state, counter advance and the issued step.
  always_comb begin
    state_next     = state;
    row_next       = row;
    col_next       = col;
    k_next         = k;
    busy           = 1'b0;
    step.valid     = 1'b0;
    step.first     = (k == '0);
    step.last_k    = (k == inner_lim);
    step.last_elem = (row == row_lim) && (col == col_lim);
    step.row       = row;
    step.col       = col;
    step.k         = k;
    case (state)
      cmm_pkg::ST_IDLE: begin
        if (go) begin
          row_next   = '0;
          col_next   = '0;
          k_next     = '0;
          state_next = cmm_pkg::ST_RUN;
        end
      end
      cmm_pkg::ST_RUN: begin
        busy       = 1'b1;
        step.valid = 1'b1;
        if (k != inner_lim) begin
          k_next = k + 1'b1;
        end else begin
          k_next = '0;
          if (col != col_lim) begin
            col_next = col + 1'b1;
          end else begin
            col_next = '0;
            if (row != row_lim) begin
              row_next = row + 1'b1;
            end else begin
              row_next   = '0;
              state_next = cmm_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = cmm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/cmm_mac.sv
`default_nettype none

// Shared complex multiply-accumulate unit. The step tag arrives with the
// read addresses; operands arrive from the stores in the next cycle.
module cmm_mac #(
  parameter int ELEM_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cmm_pkg::step_t                    step,
  input  wire logic signed [ELEM_WIDTH-1:0]      a_re,
  input  wire logic signed [ELEM_WIDTH-1:0]      a_im,
  input  wire logic signed [ELEM_WIDTH-1:0]      b_re,
  input  wire logic signed [ELEM_WIDTH-1:0]      b_im,
  output logic                                   result_valid,
  output logic [cmm_pkg::IDX_W-1:0]              out_row,
  output logic [cmm_pkg::IDX_W-1:0]              out_col,
  output logic signed [cmm_pkg::ACC_W-1:0]       prod_real,
  output logic signed [cmm_pkg::ACC_W-1:0]       prod_imag,
  output logic                                   last
);

  localparam int PW = 2 * ELEM_WIDTH;
  localparam int AW = cmm_pkg::ACC_W;

  cmm_pkg::step_t         tag1, tag2;
  logic signed [PW-1:0]   p_rr, p_ii, p_ri, p_ir;
  logic signed [AW-1:0]   e_rr, e_ii, e_ri, e_ir;
  logic signed [AW-1:0]   acc_re, acc_im;
  logic signed [AW-1:0]   acc_re_next, acc_im_next;

  // Tag pipeline, aligned with read data and then with the products.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
    end else begin
      tag1 <= step;
      tag2 <= tag1;
    end
  end

  // Four partial products, registered.
  always_ff @(posedge clk) begin
    p_rr <= a_re * b_re;
    p_ii <= a_im * b_im;
    p_ri <= a_re * b_im;
    p_ir <= a_im * b_re;
  end

  // Bring the products to accumulator width; sums wrap at that width.
  generate
    if (PW >= AW) begin : g_trunc
      assign e_rr = p_rr[AW-1:0];
      assign e_ii = p_ii[AW-1:0];
      assign e_ri = p_ri[AW-1:0];
      assign e_ir = p_ir[AW-1:0];
    end else begin : g_sext
      assign e_rr = {{(AW-PW){p_rr[PW-1]}}, p_rr};
      assign e_ii = {{(AW-PW){p_ii[PW-1]}}, p_ii};
      assign e_ri = {{(AW-PW){p_ri[PW-1]}}, p_ri};
      assign e_ir = {{(AW-PW){p_ir[PW-1]}}, p_ir};
    end
  endgenerate

  // Accumulate; the first step of an element restarts from zero.
  always_comb begin
    acc_re_next = (tag2.first ? '0 : acc_re) + e_rr - e_ii;
    acc_im_next = (tag2.first ? '0 : acc_im) + e_ri + e_ir;
  end

  always_ff @(posedge clk) begin
    if (tag2.valid) begin
      acc_re <= acc_re_next;
      acc_im <= acc_im_next;
    end
  end

  // Result register: one strobe per finished product element.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= tag2.valid && tag2.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (tag2.valid && tag2.last_k) begin
      out_row   <= tag2.row;
      out_col   <= tag2.col;
      prod_real <= acc_re_next;
      prod_imag <= acc_im_next;
      last      <= tag2.last_elem;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/complex_matrix_multiply.sv
`default_nettype none

// Complex matrix multiplier, C = A * B, Q1.15 elements, Q6.30 results.
// Commands: a command is taken at a clock edge with start high and busy low.
// Opcode 0 writes element (row_index, col_index) of A, opcode 1 of B; both
// complete in the accepting cycle and leave busy low. Opcode 2 runs a
// product; opcode 3 does nothing.
// A product runs with busy high: one complex multiply-accumulate unit (four
// multipliers) does one inner step a cycle. Each step passes the store read
// register and the product register; a finished element is then captured in
// the result register. Elements come out in row-major order, and the final
// one carries last.
// Each element is on the result ports for one cycle with result_valid high;
// the receiver cannot stall them.
// Sizes are set through the cfg channel (index 0 rows, 1 inner, 2 cols); the
// user must write them only while idle (not enforced); cfg_ready is always high.
// Reset sets all three sizes to 8 and stops any running product; the
// element stores are not cleared and must be written before use.
module complex_matrix_multiply #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         opcode,
  input  wire logic [2:0]         row_index,
  input  wire logic [2:0]         col_index,
  input  wire logic signed [15:0] elem_real,
  input  wire logic signed [15:0] elem_imag,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [3:0]         cfg_data,
  output logic                    result_valid,
  output logic [2:0]              out_row,
  output logic [2:0]              out_col,
  output logic signed [35:0]      prod_real,
  output logic signed [35:0]      prod_imag,
  output logic                    last
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
  localparam int EW     = ELEM_WIDTH;

  logic [cmm_pkg::DIM_W-1:0] rows_in_use, inner_in_use, cols_in_use;
  logic                      accept, in_range;
  logic                      we_left, we_right;
  logic signed [EW-1:0]      w_re, w_im;
  logic [ADDR_W-1:0]         waddr, a_addr, b_addr;
  logic [2*EW-1:0]           a_data, b_data;
  cmm_pkg::step_t            step;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use  <= cmm_pkg::DIM_W'(8);
      inner_in_use <= cmm_pkg::DIM_W'(8);
      cols_in_use  <= cmm_pkg::DIM_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cmm_pkg::CFG_ROWS:  rows_in_use  <= cfg_data;
        cmm_pkg::CFG_INNER: inner_in_use <= cfg_data;
        cmm_pkg::CFG_COLS:  cols_in_use  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Command transaction and element writes.
  assign accept   = start && !busy;
  assign in_range = ({1'b0, row_index} < cmm_pkg::DIM_W'(MAX_DIM)) &&
                    ({1'b0, col_index} < cmm_pkg::DIM_W'(MAX_DIM));
  assign we_left  = accept && in_range && (opcode == cmm_pkg::OP_LOAD_LEFT);
  assign we_right = accept && in_range && (opcode == cmm_pkg::OP_LOAD_RIGHT);
  assign waddr    = ADDR_W'(row_index * MAX_DIM + col_index);

  // Element width conversion of the 16-bit input parts.
  generate
    if (EW <= 16) begin : g_cut
      assign w_re = elem_real[EW-1:0];
      assign w_im = elem_imag[EW-1:0];
    end else begin : g_ext
      assign w_re = {{(EW-16){elem_real[15]}}, elem_real};
      assign w_im = {{(EW-16){elem_imag[15]}}, elem_imag};
    end
  endgenerate

  // Sequencer.
  cmm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .go        (accept && (opcode == cmm_pkg::OP_COMPUTE)),
    .row_lim   (cmm_pkg::dim_limit(rows_in_use,  cmm_pkg::DIM_W'(MAX_DIM))),
    .inner_lim (cmm_pkg::dim_limit(inner_in_use, cmm_pkg::DIM_W'(MAX_DIM))),
    .col_lim   (cmm_pkg::dim_limit(cols_in_use,  cmm_pkg::DIM_W'(MAX_DIM))),
    .busy      (busy),
    .step      (step)
  );

  // Read addresses for A(row, k) and B(k, col).
  assign a_addr = ADDR_W'(step.row * MAX_DIM + step.k);
  assign b_addr = ADDR_W'(step.k * MAX_DIM + step.col);

  // Element stores, real part in the upper half.
  cmm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (2 * EW)
  ) u_left (
    .clk   (clk),
    .we    (we_left),
    .waddr (waddr),
    .wdata ({w_re, w_im}),
    .raddr (a_addr),
    .rdata (a_data)
  );

  cmm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (2 * EW)
  ) u_right (
    .clk   (clk),
    .we    (we_right),
    .waddr (waddr),
    .wdata ({w_re, w_im}),
    .raddr (b_addr),
    .rdata (b_data)
  );

  // Shared complex multiply-accumulate unit and result register.
  cmm_mac #(
    .ELEM_WIDTH (EW)
  ) u_mac (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .a_re         (a_data[2*EW-1:EW]),
    .a_im         (a_data[EW-1:0]),
    .b_re         (b_data[2*EW-1:EW]),
    .b_im         (b_data[EW-1:0]),
    .result_valid (result_valid),
    .out_row      (out_row),
    .out_col      (out_col),
    .prod_real    (prod_real),
    .prod_imag    (prod_imag),
    .last         (last)
  );

endmodule

`default_nettype wire
